FILE: rtl/core/bls_pkg.sv
// shared constants, codes and item types of the bounded lifo stack
package bls_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 6;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef logic [CNT_W-1:0] cap_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         item_count;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

endpackage

FILE: rtl/core/bls_chan_if.sv
// valid/ready channel carrying one item of a given payload type
interface bls_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/bls_ram.sv
// generic simple dual-port ram with registered read
module bls_ram #(
    parameter int WIDTH = bls_pkg::DATA_W,
    parameter int DEPTH = bls_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bounded_lifo_stack.sv
// bounded lifo stack: top level with request decode, counter and result register
// results: push, change and failed requests register their result at acceptance;
//   successful pop and peek first pass the registered ram read in the read state
// throughput: one item per cycle for writes and failures while results are taken without stall;
//   a read blocks new items until its result is presented after the registered ram read
// reset: count cleared to empty, capacity set to 64, no result pending; entries are not cleared
module bounded_lifo_stack #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bls_chan_if.sink   req,
    bls_chan_if.source rsp,
    bls_chan_if.sink   cfg
);

    localparam int AW = $clog2(DEPTH);
    // index width wide enough for both the count and a ram address
    localparam int IW = (AW > bls_pkg::CNT_W) ? AW : bls_pkg::CNT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // control state
    logic                       state_reg;
    logic [bls_pkg::CNT_W-1:0]  count_reg;
    bls_pkg::cap_t              cap_reg;
    logic                       out_valid_reg;

    // result payload
    logic [bls_pkg::DATA_W-1:0] out_data_reg;
    logic [bls_pkg::STAT_W-1:0] out_status_reg;
    logic [bls_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_empty_reg;
    logic                       out_full_reg;

    // decode of the request at the head of the input channel
    logic                       req_fire;
    logic                       rsp_fire;
    logic [bls_pkg::CNT_W-1:0]  cap_eff;
    logic                       full_now;
    logic                       pos_ok;
    logic [bls_pkg::CNT_W-1:0]  cnt_dec;
    logic [bls_pkg::CNT_W-1:0]  count_next;
    logic [bls_pkg::STAT_W-1:0] dec_status;
    logic [bls_pkg::DATA_W-1:0] dec_data;
    logic                       dec_read;
    logic                       dec_write;
    logic                       dec_pop_slot;
    logic [IW-1:0]              cnt_wide;
    logic [IW-1:0]              top_wide;
    logic [IW-1:0]              pos_wide;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic [bls_pkg::DATA_W-1:0] ram_rdata;

    // one request at a time; the output register frees up in the same cycle it is taken
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;
    assign cfg.ready = 1'b1;

    // capacity above the ram depth is clipped to the depth
    assign cap_eff  = (int'(cap_reg) > DEPTH) ? bls_pkg::CNT_W'(DEPTH) : cap_reg;
    assign full_now = (count_reg >= cap_eff);
    assign pos_ok   = (bls_pkg::CNT_W'(req.payload.position) < count_reg);
    assign cnt_dec  = count_reg - 1'b1;

    always_comb
    begin
        count_next   = count_reg;
        dec_status   = bls_pkg::STAT_OK;
        dec_data     = '0;
        dec_read     = 1'b0;
        dec_write    = 1'b0;
        dec_pop_slot = 1'b0;
        case (req.payload.kind)
            bls_pkg::KIND_PUSH:
            begin
                if (full_now)
                begin
                    dec_status = bls_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    dec_write  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bls_pkg::KIND_POP:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bls_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    dec_read     = 1'b1;
                    dec_pop_slot = 1'b1;
                    count_next   = cnt_dec;
                end
            end
            bls_pkg::KIND_PEEK:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bls_pkg::STAT_UNDERFLOW;
                    dec_data   = '1;
                end
                else if (!pos_ok)
                begin
                    dec_status = bls_pkg::STAT_BADPOS;
                    dec_data   = '1;
                end
                else
                begin
                    dec_read = 1'b1;
                end
            end
            default:
            begin
                // change: overwrite an entry below the top
                if (!pos_ok)
                begin
                    dec_status = bls_pkg::STAT_BADPOS;
                end
                else
                begin
                    dec_write = 1'b1;
                end
            end
        endcase
    end

    // ram addressing: push writes at the count, pop reads just below it
    assign cnt_wide = IW'(count_reg);
    assign top_wide = IW'(cnt_dec);
    assign pos_wide = IW'(req.payload.position);
    assign waddr    = (req.payload.kind == bls_pkg::KIND_PUSH) ? cnt_wide[AW-1:0]
                                                               : pos_wide[AW-1:0];
    assign raddr    = dec_pop_slot ? top_wide[AW-1:0] : pos_wide[AW-1:0];

    bls_ram #(
        .WIDTH (bls_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (req_fire && dec_write),
        .waddr (waddr),
        .wdata (req.payload.value),
        .re    (req_fire && dec_read),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= bls_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.payload;
            end
            if (rsp_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        count_reg <= count_next;
                        if (dec_read)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    // read data is back from the ram, present the result
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded at acceptance; read data lands in the cycle after, in the read state
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            out_data_reg   <= dec_data;
            out_status_reg <= dec_status;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_full_reg   <= (count_next >= cap_eff);
        end
        else if (state_reg == S_READ)
        begin
            out_data_reg <= ram_rdata;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.payload.data       = out_data_reg;
    assign rsp.payload.status     = out_status_reg;
    assign rsp.payload.item_count = out_count_reg;
    assign rsp.payload.is_empty   = out_empty_reg;
    assign rsp.payload.is_full    = out_full_reg;

    // count stays within the ram
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("entry count beyond ram depth");

    // a read in flight never overlaps a pending result
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("result register busy during ram read");

    // a read returns to idle in the next cycle and shows its result
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("read result not presented");

    // an accepted push that fits grows the stack by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.payload.kind == bls_pkg::KIND_PUSH) && !full_now)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance the count");

endmodule

FILE: tb/bounded_lifo_stack_tb.sv
// self-checking testbench for the bounded lifo stack: directed corners, then random traffic
module bounded_lifo_stack_tb;

    localparam int MODEL_DEPTH = bls_pkg::DEPTH_DEF;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // extra cycles after the last result, covers the registered read path
    localparam int SETTLE_CYCLES = 3;
    // only the first few mismatches are printed, the rest are counted
    localparam int REPORT_LIMIT = 20;

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    bls_chan_if #(.payload_t(bls_pkg::req_t)) req_ch ();
    bls_chan_if #(.payload_t(bls_pkg::rsp_t)) rsp_ch ();
    bls_chan_if #(.payload_t(bls_pkg::cap_t)) cfg_ch ();

    bounded_lifo_stack uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the stack contents, the count and the capacity register
    logic [bls_pkg::DATA_W-1:0] shadow_mem [MODEL_DEPTH];
    int                         shadow_count;
    bls_pkg::cap_t              shadow_cap;

    // results predicted for accepted items, oldest first
    bls_pkg::rsp_t pending_results [$];

    // idle percentages of the sender and of the receiver
    int src_idle_pct;
    int dst_idle_pct;

    int error_count;
    int kind_seen [4];
    int status_seen [4];
    int full_seen;

    // works out the result of one request and updates the shadow stack
    function automatic bls_pkg::rsp_t next_stack_result(input bls_pkg::req_t r);
        bls_pkg::rsp_t res;
        int            limit;
        // capacity above the array size behaves as the array size
        limit = (int'(shadow_cap) > MODEL_DEPTH) ? MODEL_DEPTH : int'(shadow_cap);
        res = '0;
        res.status = bls_pkg::STAT_OK;
        case (r.kind)
            bls_pkg::KIND_PUSH:
            begin
                // full, also when capacity was lowered under the count
                if (shadow_count >= limit)
                    res.status = bls_pkg::STAT_OVERFLOW;
                else
                begin
                    shadow_mem[shadow_count[bls_pkg::POS_W-1:0]] = r.value;
                    shadow_count++;
                end
            end
            bls_pkg::KIND_POP:
            begin
                if (shadow_count == 0)
                    res.status = bls_pkg::STAT_UNDERFLOW;
                else
                begin
                    shadow_count--;
                    res.data = shadow_mem[shadow_count[bls_pkg::POS_W-1:0]];
                end
            end
            bls_pkg::KIND_PEEK:
            begin
                if (shadow_count == 0)
                begin
                    res.status = bls_pkg::STAT_UNDERFLOW;
                    res.data   = '1;
                end
                else if (int'(r.position) >= shadow_count)
                begin
                    res.status = bls_pkg::STAT_BADPOS;
                    res.data   = '1;
                end
                else
                    res.data = shadow_mem[r.position];
            end
            default:
            begin
                // change: only entries below the top may be overwritten
                if (int'(r.position) >= shadow_count)
                    res.status = bls_pkg::STAT_BADPOS;
                else
                    shadow_mem[r.position] = r.value;
            end
        endcase
        res.item_count = bls_pkg::cap_t'(shadow_count);
        res.is_empty   = (shadow_count == 0);
        res.is_full    = (shadow_count >= limit);
        return res;
    endfunction

    // offers one item after a random gap and predicts its result once accepted
    task automatic send_item(input bls_pkg::req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(next_stack_result(r));
        kind_seen[r.kind]++;
    endtask

    task automatic request(input logic [bls_pkg::KIND_W-1:0] kind, input int pos,
                           input logic [bls_pkg::DATA_W-1:0] value);
        bls_pkg::req_t r;
        r.kind     = kind;
        r.position = pos[bls_pkg::POS_W-1:0];
        r.value    = value;
        send_item(r);
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // capacity is only written with the block idle
    task automatic write_capacity(input bls_pkg::cap_t cap);
        drain_results();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_cap = cap;
    endtask

    task automatic check_field(input string what, input logic [bls_pkg::DATA_W-1:0] want,
                               input logic [bls_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // receiver: random stalls, and each accepted result is checked against the oldest one
    always @(posedge clk)
    begin
        bls_pkg::rsp_t want;
        rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual data %0h status %0d",
                             $time, rsp_ch.payload.data, rsp_ch.payload.status);
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (want.is_full)
                    full_seen++;
                check_field("data", want.data, rsp_ch.payload.data);
                check_field("status", bls_pkg::DATA_W'(want.status),
                            bls_pkg::DATA_W'(rsp_ch.payload.status));
                check_field("item_count", bls_pkg::DATA_W'(want.item_count),
                            bls_pkg::DATA_W'(rsp_ch.payload.item_count));
                check_field("is_empty", bls_pkg::DATA_W'(want.is_empty),
                            bls_pkg::DATA_W'(rsp_ch.payload.is_empty));
                check_field("is_full", bls_pkg::DATA_W'(want.is_full),
                            bls_pkg::DATA_W'(rsp_ch.payload.is_full));
            end
        end
    end

    // hang detection: any handshake restarts the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // pop, peek and change requests on an empty stack
    task automatic test_empty_stack();
        request(bls_pkg::KIND_POP, 0, 32'h0);
        request(bls_pkg::KIND_PEEK, 63, 32'h0);
        request(bls_pkg::KIND_PEEK, 0, 32'h0);
        request(bls_pkg::KIND_CHANGE, 0, 32'h1234_5678);
    endtask

    // extreme values and positions, inside and just past the top
    task automatic test_value_extremes();
        request(bls_pkg::KIND_PUSH, 0, 32'h7FFF_FFFF);
        request(bls_pkg::KIND_PUSH, 63, 32'h8000_0000);
        request(bls_pkg::KIND_PUSH, 0, 32'hFFFF_FFFF);
        request(bls_pkg::KIND_PUSH, 0, 32'h0000_0000);
        request(bls_pkg::KIND_PEEK, 0, 32'h0);
        request(bls_pkg::KIND_PEEK, 3, 32'h0);
        request(bls_pkg::KIND_PEEK, 4, 32'h0);
        request(bls_pkg::KIND_PEEK, 63, 32'h0);
        request(bls_pkg::KIND_CHANGE, 3, 32'h5555_5555);
        request(bls_pkg::KIND_CHANGE, 4, 32'hAAAA_AAAA);
        request(bls_pkg::KIND_CHANGE, 63, 32'hAAAA_AAAA);
        request(bls_pkg::KIND_PEEK, 3, 32'h0);
        request(bls_pkg::KIND_POP, 0, 32'h0);
    endtask

    // capacity lowered under the count, capacity one, and capacity zero
    task automatic test_capacity_limits();
        write_capacity(bls_pkg::cap_t'(1));
        request(bls_pkg::KIND_PUSH, 0, 32'h0BAD_F00D);
        request(bls_pkg::KIND_POP, 0, 32'h0);
        request(bls_pkg::KIND_POP, 0, 32'h0);
        request(bls_pkg::KIND_POP, 0, 32'h0);
        request(bls_pkg::KIND_PUSH, 0, 32'h0000_0001);
        request(bls_pkg::KIND_PUSH, 0, 32'h0000_0002);
        request(bls_pkg::KIND_POP, 0, 32'h0);
        write_capacity(bls_pkg::cap_t'(0));
        request(bls_pkg::KIND_PUSH, 0, 32'hFFFF_FFFE);
    endtask

    // capacity above the array size, filled to the last entry and one more
    task automatic test_full_depth();
        write_capacity(bls_pkg::cap_t'(127));
        repeat (MODEL_DEPTH + 1)
            request(bls_pkg::KIND_PUSH, 0, $urandom);
        request(bls_pkg::KIND_PEEK, 63, 32'h0);
        request(bls_pkg::KIND_CHANGE, 63, $urandom);
        request(bls_pkg::KIND_PEEK, 63, 32'h0);
    endtask

    function automatic bls_pkg::cap_t pick_capacity();
        case ($urandom_range(5))
            0, 1:    return bls_pkg::cap_t'($urandom_range(1, 6));
            2:       return bls_pkg::CAP_RESET;
            3:       return bls_pkg::cap_t'($urandom_range(65, 127));
            4:       return bls_pkg::cap_t'($urandom_range(0, 127));
            default: return bls_pkg::cap_t'($urandom_range(7, 63));
        endcase
    endfunction

    // growing blocks lean to pushes, shrinking ones to pops; positions mostly below the top
    function automatic bls_pkg::req_t random_request(input bit grow);
        bls_pkg::req_t r;
        int            roll;
        roll = $urandom_range(99);
        if (grow)
            r.kind = (roll < 55) ? bls_pkg::KIND_PUSH : (roll < 70) ? bls_pkg::KIND_POP
                   : (roll < 85) ? bls_pkg::KIND_PEEK : bls_pkg::KIND_CHANGE;
        else
            r.kind = (roll < 20) ? bls_pkg::KIND_PUSH : (roll < 60) ? bls_pkg::KIND_POP
                   : (roll < 80) ? bls_pkg::KIND_PEEK : bls_pkg::KIND_CHANGE;
        if (shadow_count > 0 && $urandom_range(4) != 0)
            r.position = bls_pkg::POS_W'($urandom_range(shadow_count - 1));
        else
            r.position = bls_pkg::POS_W'($urandom_range(63));
        case ($urandom_range(9))
            0:       r.value = 32'h7FFF_FFFF;
            1:       r.value = 32'h8000_0000;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    // three idle profiles, each with three capacity settings
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 30;
                    dst_idle_pct = 83;
                end
                1:
                begin
                    src_idle_pct = 83;
                    dst_idle_pct = 30;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                write_capacity(pick_capacity());
                repeat (62)
                    send_item(random_request(blk != 1));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        shadow_count = 0;
        shadow_cap   = bls_pkg::CAP_RESET;
        src_idle_pct = 30;
        dst_idle_pct = 83;
        error_count  = 0;
        full_seen    = 0;
        foreach (kind_seen[i])
        begin
            kind_seen[i]   = 0;
            status_seen[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_value_extremes();
        test_capacity_limits();
        test_full_depth();
        test_random_traffic();

        drain_results();
        $display("covered %0d push, %0d pop, %0d peek, %0d change requests",
                 kind_seen[bls_pkg::KIND_PUSH], kind_seen[bls_pkg::KIND_POP],
                 kind_seen[bls_pkg::KIND_PEEK], kind_seen[bls_pkg::KIND_CHANGE]);
        $display("results: %0d ok, %0d overflow, %0d underflow, %0d bad position, %0d full",
                 status_seen[bls_pkg::STAT_OK], status_seen[bls_pkg::STAT_OVERFLOW],
                 status_seen[bls_pkg::STAT_UNDERFLOW], status_seen[bls_pkg::STAT_BADPOS],
                 full_seen);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
